// ----- rtl/core/bhpq_pkg.sv -----
`default_nettype none

package bhpq_pkg;

    // Store geometry and key format.
    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    // Child indexes reach 2 * CAPACITY, so they get two bits beyond the address.
    localparam int CHILD_W   = ADDR_W + 2;

    // Stream payload widths.
    localparam int S_DATA_W  = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int M_FIELD_W = 2 * KEY_WIDTH + COUNT_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int STATUS_W  = 2;
    localparam int M_USER_W  = 8;

    // Action codes carried on the input tuser.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COUNT_W-1:0] count_t;

    // True when key a must sit strictly above key b in the current order.
    function automatic logic better(input key_t a, input key_t b, input logic max_first);
        logic res;
        res = max_first ? (a > b) : (a < b);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/binary_heap_priority_queue_core.sv -----
`default_nettype none
// Channel   Direction  Handshake                  Payload
// s_        in         s_tvalid / s_tready        push or pop transaction with key
// m_        out        m_tvalid / m_tready        popped key, new top, count, status
// cfg_      in         cfg_valid / cfg_ready      max_first order select
//
// A push climbs the heap one level at a time, comparing with the parent; a pop
// descends one level at a time and reads the two children of each level in turn
// through the single read port of the heap memory. Reset empties the heap and
// selects min-first order; the memory contents need no clearing. A stalled result
// channel holds the finished transaction in the output register; one more
// transaction may be taken and worked on meanwhile, and its result waits until
// the output register frees.

module binary_heap_priority_queue_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bhpq_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] key_value
    input  wire logic                          s_tuser,  // [0] action
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [bhpq_pkg::M_DATA_W-1:0] m_tdata,  // [31:0] popped_key,
                                                         // [63:32] top_key,
                                                         // [74:64] entry_total, zero pad
    output logic      [bhpq_pkg::M_USER_W-1:0] m_tuser,  // [1:0] status, zero pad
    // Configuration.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data  // max_first
);

    import bhpq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CMP  = 4'd1;
    localparam logic [3:0] S_UP_FIN  = 4'd2;
    localparam logic [3:0] S_DN_LAST = 4'd3;
    localparam logic [3:0] S_DN_CHK  = 4'd4;
    localparam logic [3:0] S_DN_L    = 4'd5;
    localparam logic [3:0] S_DN_R    = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    logic [3:0]            state_reg, state_next;
    count_t                count_reg, count_next;
    addr_t                 pos_reg, pos_next;
    key_t                  key_reg, key_next;
    key_t                  left_reg, left_next;
    key_t                  root_reg, root_next;
    key_t                  popped_reg, popped_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  max_first_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [M_USER_W-1:0]   m_tuser_reg;

    logic                  ram_we;
    addr_t                 ram_waddr;
    key_t                  ram_wdata;
    addr_t                 ram_raddr;
    logic [KEY_WIDTH-1:0]  ram_rdata;
    key_t                  rd_key;

    logic                  in_fire;
    logic                  out_free;
    addr_t                 cnt_m1;
    addr_t                 pos_parent;
    addr_t                 parent_of_parent;
    logic [CHILD_W-1:0]    lc;
    logic [CHILD_W-1:0]    rc;
    logic [CHILD_W-1:0]    n_ext;
    key_t                  top_key;

    bhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_key           = key_t'(ram_rdata);
    assign in_fire          = s_tvalid && s_tready;
    assign out_free         = !m_tvalid_reg || m_tready;
    assign s_tready         = (state_reg == S_IDLE);
    assign cfg_ready        = 1'b1;
    assign cnt_m1           = ADDR_W'(count_reg - count_t'(1));
    assign pos_parent       = ADDR_W'((pos_reg - addr_t'(1)) >> 1);
    assign parent_of_parent = ADDR_W'((pos_parent - addr_t'(1)) >> 1);
    assign lc               = {1'b0, pos_reg, 1'b1};
    assign rc               = lc + CHILD_W'(1);
    assign n_ext            = CHILD_W'(count_reg);
    assign top_key          = (count_reg != '0) ? root_reg : key_t'(0);

    // The moving key is held in key_reg and only written to the store once its
    // final slot is known; each level moves the displaced neighbor into the hole.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        left_next   = left_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = key_reg;
        ram_raddr   = pos_parent;

        case (state_reg)
            S_IDLE: begin
                // Prefetch the parent of the new slot for a push, or the last
                // entry for a pop.
                ram_raddr = (s_tuser == ACT_POP) ? cnt_m1 : ADDR_W'(cnt_m1 >> 1);
                if (in_fire) begin
                    popped_next = '0;
                    status_next = ST_OK;
                    if (s_tuser == ACT_PUSH) begin
                        if (count_reg == count_t'(CAPACITY)) begin
                            status_next = ST_PUSH_FULL;
                            state_next  = S_DONE;
                        end else begin
                            key_next   = key_t'(s_tdata[KEY_WIDTH-1:0]);
                            pos_next   = ADDR_W'(count_reg);
                            count_next = count_reg + count_t'(1);
                            state_next = (count_reg == '0) ? S_UP_FIN : S_UP_CMP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_POP_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            popped_next = root_reg;
                            count_next  = count_reg - count_t'(1);
                            state_next  = (count_reg == count_t'(1)) ? S_DONE : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_CMP: begin
                if (better(key_reg, rd_key, max_first_reg)) begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_key;
                    pos_next  = pos_parent;
                    ram_raddr = parent_of_parent;
                    if (pos_parent == '0) begin
                        state_next = S_UP_FIN;
                    end
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_UP_FIN: begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DN_LAST: begin
                key_next   = rd_key;
                pos_next   = '0;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: begin
                ram_raddr = lc[ADDR_W-1:0];
                if (lc >= n_ext) begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_L;
                end
            end
            S_DN_L: begin
                left_next = rd_key;
                ram_raddr = rc[ADDR_W-1:0];
                if (rc < n_ext) begin
                    state_next = S_DN_R;
                end else if (better(rd_key, key_reg, max_first_reg)) begin
                    ram_we     = 1'b1;
                    ram_wdata  = rd_key;
                    pos_next   = lc[ADDR_W-1:0];
                    state_next = S_DN_CHK;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_R: begin
                ram_we = 1'b1;
                // Left wins a tie with the right child.
                if (better(left_reg, key_reg, max_first_reg)) begin
                    if (better(rd_key, left_reg, max_first_reg)) begin
                        ram_wdata = rd_key;
                        pos_next  = rc[ADDR_W-1:0];
                    end else begin
                        ram_wdata = left_reg;
                        pos_next  = lc[ADDR_W-1:0];
                    end
                    state_next = S_DN_CHK;
                end else if (better(rd_key, key_reg, max_first_reg)) begin
                    ram_wdata  = rd_key;
                    pos_next   = rc[ADDR_W-1:0];
                    state_next = S_DN_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The root is mirrored in a register so the result never needs a read.
    assign root_next = (ram_we && ram_waddr == '0) ? ram_wdata : root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_first_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                max_first_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        left_reg   <= left_next;
        root_reg   <= root_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (state_reg == S_DONE && out_free) begin
            m_tdata_reg <= M_DATA_W'({count_reg, top_key, popped_reg});
            m_tuser_reg <= M_USER_W'(status_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Only occupied slots are ever written.
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (COUNT_W'(ram_waddr) < count_reg))
        else $error("heap write beyond the occupied range");

    // A push that fits grows the heap by exactly one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == ACT_PUSH && count_reg != count_t'(CAPACITY))
        |=> (count_reg == $past(count_reg) + count_t'(1)))
        else $error("push did not grow the heap");

    // A pop on an empty heap leaves it empty.
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == ACT_POP && count_reg == '0) |=> (count_reg == '0))
        else $error("pop on empty heap changed the count");

    // A flagged transaction reports no popped key.
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[STATUS_W-1:0] != ST_OK) |-> (m_tdata[KEY_WIDTH-1:0] == '0))
        else $error("flagged result carries a popped key");

endmodule

`default_nettype wire

// ----- rtl/core/bhpq_ram.sv -----
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Simple dual-port array with a registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
